// ===== src/itrd_pkg.sv =====
package itrd_pkg;

  // Data widths fixed by the item fields and configuration registers.
  localparam int unsigned NUMBER_W   = 32;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned LEN_W      = 5;

  // Alphabet and digit limits.
  localparam int unsigned MIN_BASE    = 2;
  localparam int unsigned MAX_BASE    = 16;
  localparam int unsigned ALPHA_SLOTS = 16;
  localparam int unsigned DIGIT_W     = 4;
  localparam int unsigned MAX_DIGITS  = 32;
  localparam int unsigned STACK_IDX_W = $clog2(MAX_DIGITS);
  localparam int unsigned COUNT_W     = $clog2(MAX_DIGITS + 1);

  // Iterative divider: quotient bits resolved per cycle and cycles per digit.
  localparam int unsigned BITS_PER_CYCLE = 4;
  localparam int unsigned DIV_CYCLES     = NUMBER_W / BITS_PER_CYCLE;
  localparam int unsigned STEP_W         = $clog2(DIV_CYCLES);

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BASE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIGITS_HIGH = 2'd2;

  // Configured alphabet.
  typedef struct packed {
    logic [LEN_W-1:0]      base_length;
    logic [CFG_DATA_W-1:0] digits_high;
    logic [CFG_DATA_W-1:0] digits_low;
  } cfg_t;

  // A classified item as it travels from the front to the back part.
  typedef struct packed {
    logic                neg;
    logic                bad;
    logic [NUMBER_W-1:0] magnitude;
  } job_t;

  // Alphabet character at a given digit index.
  function automatic logic [CHAR_W-1:0] alpha_char(cfg_t cfg, logic [DIGIT_W-1:0] idx);
    logic [2*CFG_DATA_W-1:0] digits;
    digits = {cfg.digits_high, cfg.digits_low};
    return digits[{idx, 3'b000} +: CHAR_W];
  endfunction

endpackage

// ===== src/itrd_stream_if.sv =====
// Input channel: one signed number per item.
interface itrd_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

// Output channel: one character per item.
interface itrd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;
  logic       base_bad;

  modport source (output valid, output character, output last, output base_bad, input ready);
  modport sink (input valid, input character, input last, input base_bad, output ready);
endinterface

// ===== src/itrd_front.sv =====
module itrd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  itrd_pkg::cfg_t  cfg_i,
  itrd_in_if.sink         num_i,
  output logic            job_valid_o,
  output itrd_pkg::job_t  job_o,
  input  logic            job_ready_i
);
  import itrd_pkg::*;

  logic                stg_valid_q, stg_valid_d;
  job_t                stg_q;
  logic                accept;
  logic                alpha_bad;
  logic [NUMBER_W-1:0] raw;

  // Alphabet check: length bounds, sign characters and repeats.
  always_comb begin
    alpha_bad = (cfg_i.base_length < LEN_W'(MIN_BASE)) ||
                (cfg_i.base_length > LEN_W'(MAX_BASE));
    for (int i = 0; i < ALPHA_SLOTS; i++) begin
      if (LEN_W'(i) < cfg_i.base_length) begin
        if ((alpha_char(cfg_i, DIGIT_W'(i)) == CH_MINUS) ||
            (alpha_char(cfg_i, DIGIT_W'(i)) == CH_PLUS)) begin
          alpha_bad = 1'b1;
        end
        for (int j = i + 1; j < ALPHA_SLOTS; j++) begin
          if ((LEN_W'(j) < cfg_i.base_length) &&
              (alpha_char(cfg_i, DIGIT_W'(i)) == alpha_char(cfg_i, DIGIT_W'(j)))) begin
            alpha_bad = 1'b1;
          end
        end
      end
    end
  end

  // Single holding stage in front of the queue.
  assign num_i.ready = !stg_valid_q || job_ready_i;
  assign accept      = num_i.valid && num_i.ready;
  assign raw         = unsigned'(num_i.number);

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (job_ready_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  // Sign, unsigned magnitude and alphabet verdict are captured per item.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q.neg       <= raw[NUMBER_W-1];
      stg_q.bad       <= alpha_bad;
      stg_q.magnitude <= raw[NUMBER_W-1] ? (NUMBER_W'(0) - raw) : raw;
    end
  end

  assign job_valid_o = stg_valid_q;
  assign job_o       = stg_q;

endmodule

// ===== src/itrd_fifo.sv =====
module itrd_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  itrd_pkg::job_t  push_data_i,
  output logic            push_ready_o,
  output logic            pop_valid_o,
  output itrd_pkg::job_t  pop_data_o,
  input  logic            pop_ready_i
);
  import itrd_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = (cnt_q != CNT_W'(QUEUE_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Pointer and fill-level bookkeeping.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== src/itrd_back.sv =====
module itrd_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  itrd_pkg::cfg_t  cfg_i,
  input  logic            job_valid_i,
  input  itrd_pkg::job_t  job_i,
  output logic            job_ready_o,
  itrd_out_if.source      chr_o
);
  import itrd_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_SIGN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]          state_q, state_d;
  logic                neg_q, neg_d;
  logic [NUMBER_W-1:0] quo_q, quo_d;
  logic [DIGIT_W-1:0]  rem_q, rem_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;
  logic [DIGIT_W-1:0]  stack_q [MAX_DIGITS];
  logic                push_digit;

  logic                ovalid_q, ovalid_d;
  logic [CHAR_W-1:0]   ochar_q, ochar_d;
  logic                olast_q, olast_d;
  logic                obad_q, obad_d;
  logic                load_out;

  logic                slot_free;
  logic [LEN_W-1:0]    r;
  logic [NUMBER_W-1:0] qq;
  logic [COUNT_W-1:0]  idx;

  // The output register may be refilled when empty or taken this cycle.
  assign slot_free   = !ovalid_q || chr_o.ready;
  assign job_ready_o = (state_q == ST_IDLE) && slot_free;
  assign idx         = cnt_q - 1'b1;

  // Restoring division step: a few quotient bits per cycle.
  always_comb begin
    r  = {1'b0, rem_q};
    qq = quo_q;
    for (int k = 0; k < BITS_PER_CYCLE; k++) begin
      r  = {r[LEN_W-2:0], qq[NUMBER_W-1]};
      qq = {qq[NUMBER_W-2:0], 1'b0};
      if (r >= cfg_i.base_length) begin
        r     = r - cfg_i.base_length;
        qq[0] = 1'b1;
      end
    end
  end

  // Sequencer: divide out digits, then send sign and digits most significant first (bad alphabet: at most the '-').
  always_comb begin
    state_d    = state_q;
    neg_d      = neg_q;
    quo_d      = quo_q;
    rem_d      = rem_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    push_digit = 1'b0;
    load_out   = 1'b0;
    ochar_d    = ochar_q;
    olast_d    = olast_q;
    obad_d     = obad_q;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i && slot_free) begin
          neg_d  = job_i.neg;
          quo_d  = job_i.magnitude;
          rem_d  = '0;
          step_d = '0;
          cnt_d  = '0;
          if (job_i.bad) begin
            if (job_i.neg) begin
              load_out = 1'b1;
              ochar_d  = CH_MINUS;
              olast_d  = 1'b1;
              obad_d   = 1'b1;
            end
          end else begin
            state_d = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        quo_d  = qq;
        rem_d  = r[DIGIT_W-1:0];
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_CYCLES - 1)) begin
          push_digit = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          rem_d      = '0;
          if ((qq == '0) || (cnt_q == COUNT_W'(MAX_DIGITS - 1))) begin
            state_d = neg_q ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          load_out = 1'b1;
          ochar_d  = CH_MINUS;
          olast_d  = 1'b0;
          obad_d   = 1'b0;
          state_d  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          load_out = 1'b1;
          ochar_d  = alpha_char(cfg_i, stack_q[idx[STACK_IDX_W-1:0]]);
          olast_d  = (idx == '0);
          obad_d   = 1'b0;
          cnt_d    = idx;
          if (idx == '0) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    ovalid_d = ovalid_q;
    if (load_out) begin
      ovalid_d = 1'b1;
    end else if (chr_o.ready) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      step_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      step_q   <= step_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Datapath registers and the digit stack.
  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    ochar_q <= ochar_d;
    olast_q <= olast_d;
    obad_q  <= obad_d;
    if (push_digit) begin
      stack_q[cnt_q[STACK_IDX_W-1:0]] <= r[DIGIT_W-1:0];
    end
  end

  assign chr_o.valid     = ovalid_q;
  assign chr_o.character = ochar_q;
  assign chr_o.last      = olast_q;
  assign chr_o.base_bad  = obad_q;

endmodule

// ===== src/integer_to_radix_digits_core.sv =====
// Converts each signed 32-bit number into its text in the configured base, one
// character per output item, most significant digit first, with a leading '-'
// for negative numbers; last marks the final character of a number. With a bad
// alphabet only the '-' of a negative number appears, flagged by base_bad, and a
// non-negative number produces nothing. Digits come from a shared restoring
// divider that resolves four quotient bits per cycle, and a two-entry queue
// lets the next number be accepted meanwhile. Write the alphabet only while
// no number is in flight.
module integer_to_radix_digits_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [itrd_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [itrd_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  itrd_in_if.sink                                num_i,
  itrd_out_if.source                             chr_o
);
  import itrd_pkg::*;

  cfg_t cfg_q;
  logic fr_valid, fr_ready;
  job_t fr_job;
  logic bk_valid, bk_ready;
  job_t bk_job;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BASE_LENGTH: cfg_q.base_length <= cfg_data_i[LEN_W-1:0];
        REG_DIGITS_LOW:  cfg_q.digits_low  <= cfg_data_i;
        REG_DIGITS_HIGH: cfg_q.digits_high <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  itrd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .num_i       (num_i),
    .job_valid_o (fr_valid),
    .job_o       (fr_job),
    .job_ready_i (fr_ready)
  );

  itrd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_data_i  (fr_job),
    .push_ready_o (fr_ready),
    .pop_valid_o  (bk_valid),
    .pop_data_o   (bk_job),
    .pop_ready_i  (bk_ready)
  );

  itrd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (bk_valid),
    .job_i       (bk_job),
    .job_ready_o (bk_ready),
    .chr_o       (chr_o)
  );

endmodule

// ===== verif/integer_to_radix_digits_core_tb.sv =====
module integer_to_radix_digits_core_tb;
  import itrd_pkg::*;

  // One output character as the checker expects it.
  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
    logic              base_bad;
  } char_item_t;

  typedef enum logic {
    ROW_ALPHABET,
    ROW_NUMBER
  } row_kind_e;

  typedef enum int {
    ALPHA_GOOD,
    ALPHA_BAD_LENGTH,
    ALPHA_SIGN,
    ALPHA_REPEAT
  } alpha_kind_e;

  // One row of the directed table: either a new alphabet or a number to convert.
  typedef struct packed {
    row_kind_e             kind;
    logic                  check_typed;
    logic [CFG_DATA_W-1:0] base_length;
    logic [CFG_DATA_W-1:0] digits_low;
    logic [CFG_DATA_W-1:0] digits_high;
    logic [NUMBER_W-1:0]   number;
    logic [95:0]           text;
    logic [3:0]            text_len;
    logic                  base_bad;
  } stim_row_t;

  localparam int N_DIRECTED      = 37;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 27;
  localparam int SETTLE_CYCLES   = 400;
  localparam int DRAIN_LIMIT     = 50000;
  localparam int MAX_GAP         = 13;

  localparam logic [CFG_DATA_W-1:0] DEC_LOW  = 64'h3736353433323130;
  localparam logic [CFG_DATA_W-1:0] DEC_HIGH = 64'h0000000000003938;
  localparam logic [CFG_DATA_W-1:0] HEX_HIGH = 64'h6665646362613938;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  itrd_in_if  num_if ();
  itrd_out_if chr_if ();

  integer_to_radix_digits_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .num_i      (num_if),
    .chr_o      (chr_if)
  );

  // Shadow copy of the alphabet registers.
  logic [LEN_W-1:0]      alpha_len;
  logic [CFG_DATA_W-1:0] alpha_low;
  logic [CFG_DATA_W-1:0] alpha_high;

  char_item_t expected_chars[$];
  stim_row_t  directed_rows [N_DIRECTED];
  int         fail_count;
  bit         no_idle;

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Safety net against a hung run.
  initial begin
    #4000000;
    $display("RESULT: ERROR");
    $finish;
  end

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic [CHAR_W-1:0] alpha_byte(int unsigned idx);
    logic [2*CFG_DATA_W-1:0] table_bits;
    table_bits = {alpha_high, alpha_low} >> (8 * idx);
    return table_bits[CHAR_W-1:0];
  endfunction

  // An alphabet is usable if its length is in range and the characters within
  // that length are distinct and free of sign characters.
  function automatic bit alphabet_valid();
    logic [CHAR_W-1:0] c;
    if (alpha_len < MIN_BASE || alpha_len > MAX_BASE) return 1'b0;
    for (int i = 0; i < alpha_len; i++) begin
      c = alpha_byte(i);
      if (c == CH_MINUS || c == CH_PLUS) return 1'b0;
      for (int j = i + 1; j < alpha_len; j++) begin
        if (alpha_byte(j) == c) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic void push_char(logic [CHAR_W-1:0] c, logic last, logic bad);
    char_item_t item;
    item.character = c;
    item.last      = last;
    item.base_bad  = bad;
    expected_chars.push_back(item);
  endfunction

  // Works out the characters that one number turns into under the current alphabet.
  function automatic void predict_text(logic [NUMBER_W-1:0] value);
    logic [NUMBER_W-1:0] mag;
    logic [NUMBER_W-1:0] radix;
    logic [NUMBER_W-1:0] rem;
    logic [DIGIT_W-1:0]  digits [MAX_DIGITS];
    int                  n;
    mag = value[NUMBER_W-1] ? (32'd0 - value) : value;
    if (!alphabet_valid()) begin
      if (value[NUMBER_W-1]) push_char(CH_MINUS, 1'b1, 1'b1);
      return;
    end
    radix = NUMBER_W'(alpha_len);
    n = 0;
    do begin
      rem = mag % radix;
      digits[n] = rem[DIGIT_W-1:0];
      mag = mag / radix;
      n++;
    end while (mag != 0 && n < MAX_DIGITS);
    if (value[NUMBER_W-1]) push_char(CH_MINUS, 1'b0, 1'b0);
    for (int k = n - 1; k >= 0; k--) begin
      push_char(alpha_byte(digits[k]), k == 0, 1'b0);
    end
  endfunction

  function automatic stim_row_t alpha_row(logic [CFG_DATA_W-1:0] len_word,
                                          logic [CFG_DATA_W-1:0] lo,
                                          logic [CFG_DATA_W-1:0] hi);
    stim_row_t r;
    r = '0;
    r.kind        = ROW_ALPHABET;
    r.base_length = len_word;
    r.digits_low  = lo;
    r.digits_high = hi;
    return r;
  endfunction

  function automatic stim_row_t model_row(logic [NUMBER_W-1:0] value);
    stim_row_t r;
    r = '0;
    r.kind   = ROW_NUMBER;
    r.number = value;
    return r;
  endfunction

  function automatic stim_row_t typed_row(logic [NUMBER_W-1:0] value, logic [95:0] text,
                                          int len, logic bad);
    stim_row_t r;
    r = '0;
    r.kind        = ROW_NUMBER;
    r.check_typed = 1'b1;
    r.number      = value;
    r.text        = text;
    r.text_len    = 4'(len);
    r.base_bad    = bad;
    return r;
  endfunction

  function automatic logic [NUMBER_W-1:0] random_number();
    logic [NUMBER_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = 32'h8000_0000;
      2:       v = 32'h7FFF_FFFF;
      3:       v = 32'hFFFF_FFFF;
      4, 5:    v = $urandom_range(0, 255);
      default: v = $urandom;
    endcase
    if ($urandom_range(0, 5) == 0) v = 32'd0 - v;
    return v;
  endfunction

  // Offers one number and returns at the edge where it is accepted.
  task automatic send_number(logic [NUMBER_W-1:0] value);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      num_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    num_if.valid  <= 1'b1;
    num_if.number <= value;
    do @(posedge clk_i); while (!(num_if.valid && num_if.ready));
  endtask

  task automatic stop_numbers();
    num_if.valid <= 1'b0;
  endtask

  // Waits for every expected character, then lets any silent item finish.
  task automatic wait_idle();
    int n;
    n = 0;
    while (expected_chars.size() != 0 && n < DRAIN_LIMIT) begin
      @(posedge clk_i);
      n++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_alphabet(logic [CFG_DATA_W-1:0] len_word,
                              logic [CFG_DATA_W-1:0] lo,
                              logic [CFG_DATA_W-1:0] hi);
    cfg_we   <= 1'b1;
    cfg_idx  <= REG_BASE_LENGTH;
    cfg_data <= len_word;
    @(posedge clk_i);
    cfg_idx  <= REG_DIGITS_LOW;
    cfg_data <= lo;
    @(posedge clk_i);
    cfg_idx  <= REG_DIGITS_HIGH;
    cfg_data <= hi;
    @(posedge clk_i);
    cfg_we     <= 1'b0;
    alpha_len  = len_word[LEN_W-1:0];
    alpha_low  = lo;
    alpha_high = hi;
  endtask

  // Builds a random alphabet, usually valid, sometimes broken in one way.
  task automatic random_alphabet();
    logic [CHAR_W-1:0]     bytes [ALPHA_SLOTS];
    logic [CFG_DATA_W-1:0] len_word;
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    alpha_kind_e           kind;
    int                    len;
    int                    i;
    int                    j;
    int                    r;
    bit                    clash;
    r = $urandom_range(0, 9);
    kind = (r < 7) ? ALPHA_GOOD : (r == 7) ? ALPHA_BAD_LENGTH :
           (r == 8) ? ALPHA_SIGN : ALPHA_REPEAT;
    len = $urandom_range(MIN_BASE, MAX_BASE);
    if ($urandom_range(0, 3) == 0) len = $urandom_range(0, 1) ? MIN_BASE : MAX_BASE;
    for (i = 0; i < ALPHA_SLOTS; i++) begin
      if (i < len) begin
        do begin
          bytes[i] = CHAR_W'($urandom_range(0, 255));
          clash = (bytes[i] == CH_MINUS) || (bytes[i] == CH_PLUS);
          for (j = 0; j < i; j++) clash |= (bytes[j] == bytes[i]);
        end while (clash);
      end else begin
        bytes[i] = CHAR_W'($urandom_range(0, 255));
      end
    end
    case (kind)
      ALPHA_BAD_LENGTH: begin
        r = $urandom_range(0, 16);
        len = (r < 2) ? r : r + 15;
      end
      ALPHA_SIGN: begin
        bytes[$urandom_range(0, len - 1)] = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
      end
      ALPHA_REPEAT: begin
        i = $urandom_range(0, len - 2);
        j = $urandom_range(i + 1, len - 1);
        bytes[j] = bytes[i];
      end
      default: ;
    endcase
    for (i = 0; i < 8; i++) begin
      lo[8*i +: 8] = bytes[i];
      hi[8*i +: 8] = bytes[i+8];
    end
    // Bits above the length field carry noise that the block must ignore.
    len_word = {$urandom, $urandom};
    len_word[LEN_W-1:0] = LEN_W'(len);
    set_alphabet(len_word, lo, hi);
  endtask

  // Output side: random back-pressure and comparison of each character item.
  initial begin
    int         stall;
    char_item_t want;
    chr_if.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = draw_gap();
      if (stall > 0) begin
        chr_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      chr_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(chr_if.valid && chr_if.ready));
      if (expected_chars.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected item, expected none, got character %h last %b base_bad %b",
                 $time, chr_if.character, chr_if.last, chr_if.base_bad);
      end else begin
        want = expected_chars.pop_front();
        if (chr_if.character !== want.character) begin
          fail_count++;
          $display("%0t: character mismatch, expected %h, got %h",
                   $time, want.character, chr_if.character);
        end
        if (chr_if.last !== want.last) begin
          fail_count++;
          $display("%0t: last mismatch, expected %b, got %b", $time, want.last, chr_if.last);
        end
        if (chr_if.base_bad !== want.base_bad) begin
          fail_count++;
          $display("%0t: base_bad mismatch, expected %b, got %b",
                   $time, want.base_bad, chr_if.base_bad);
        end
      end
    end
  end

  // Input side and overall sequencing.
  initial begin
    stim_row_t row;
    logic [NUMBER_W-1:0] value;
    cfg_we        = 1'b0;
    cfg_idx       = REG_BASE_LENGTH;
    cfg_data      = '0;
    num_if.valid  = 1'b0;
    num_if.number = '0;
    rst_ni        = 1'b0;
    alpha_len     = '0;
    alpha_low     = '0;
    alpha_high    = '0;
    fail_count    = 0;
    no_idle       = 1'b0;

    directed_rows = '{
      // Straight after reset the alphabet is empty.
      typed_row(32'd5, "", 0, 1'b0),
      typed_row(32'hFFFF_FFFF, "-", 1, 1'b1),
      alpha_row(64'd10, DEC_LOW, DEC_HIGH),
      typed_row(32'd0, "0", 1, 1'b0),
      typed_row(32'h8000_0000, "-2147483648", 11, 1'b0),
      typed_row(32'h7FFF_FFFF, "2147483647", 10, 1'b0),
      typed_row(32'hFFFF_FFFF, "-1", 2, 1'b0),
      model_row(32'd1234567),
      alpha_row(64'd16, DEC_LOW, HEX_HIGH),
      typed_row(32'h7FFF_FFFF, "7fffffff", 8, 1'b0),
      typed_row(32'h8000_0000, "-80000000", 9, 1'b0),
      model_row(-32'sd48879),
      alpha_row(64'd2, 64'h3130, 64'h0),
      typed_row(32'd0, "0", 1, 1'b0),
      model_row(32'h8000_0000),
      model_row(32'h7FFF_FFFF),
      // Lengths beyond the table size.
      alpha_row(64'd17, DEC_LOW, HEX_HIGH),
      typed_row(-32'sd7, "-", 1, 1'b1),
      typed_row(32'd7, "", 0, 1'b0),
      alpha_row(64'd31, DEC_LOW, HEX_HIGH),
      typed_row(-32'sd100, "-", 1, 1'b1),
      // Sign characters and repeats within the length, and a length below the minimum.
      alpha_row(64'd3, 64'h62612B, 64'h0),
      typed_row(-32'sd3, "-", 1, 1'b1),
      typed_row(32'd3, "", 0, 1'b0),
      alpha_row(64'd3, 64'h792D78, 64'h0),
      typed_row(-32'sd9, "-", 1, 1'b1),
      alpha_row(64'd4, 64'h61636261, 64'h0),
      typed_row(32'd9, "", 0, 1'b0),
      alpha_row(64'd1, 64'h61, 64'h0),
      typed_row(32'hFFFF_FFFF, "-", 1, 1'b1),
      // A zero byte is an ordinary digit; signs and repeats past the length do not count.
      alpha_row(64'd2, 64'h2B2B2B2B2B2B3100, 64'h2B2B2B2B2B2B2B2B),
      model_row(32'd2),
      model_row(-32'sd5),
      alpha_row(64'd2, 64'h6161616161616261, 64'h6161616161616161),
      model_row(-32'sd6),
      alpha_row(64'd0, 64'h0, 64'h0),
      typed_row(32'h8000_0000, "-", 1, 1'b1)
    };

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part.
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_ALPHABET) begin
        stop_numbers();
        wait_idle();
        set_alphabet(row.base_length, row.digits_low, row.digits_high);
      end else begin
        send_number(row.number);
        if (row.check_typed) begin
          for (int k = 0; k < row.text_len; k++) begin
            push_char(row.text[8*(row.text_len-1-k) +: 8], k == row.text_len - 1,
                      row.base_bad);
          end
        end else begin
          predict_text(row.number);
        end
      end
    end

    // Random part: a fresh alphabet per phase, some phases without idling.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      stop_numbers();
      wait_idle();
      no_idle = (p % 3 == 2);
      random_alphabet();
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        value = random_number();
        send_number(value);
        predict_text(value);
      end
    end

    stop_numbers();
    wait_idle();
    if (expected_chars.size() != 0) begin
      fail_count++;
      $display("%0t: missing items, expected %0d more characters, got none",
               $time, expected_chars.size());
    end
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/itrd_pkg.sv
src/itrd_stream_if.sv
src/itrd_front.sv
src/itrd_fifo.sv
src/itrd_back.sv
src/integer_to_radix_digits_core.sv
verif/integer_to_radix_digits_core_tb.sv
